// ===== src/palindromic_prime_range_sum_assert.svh =====
// ---------------------------------------------------------------------------
// Palindromic prime range sum: assertion macros
// Shared property wrappers clocked on i_clk and disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef PALINDROMIC_PRIME_RANGE_SUM_ASSERT_SVH
`define PALINDROMIC_PRIME_RANGE_SUM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPRS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/pprs_pkg.sv =====
// ---------------------------------------------------------------------------
// Palindromic prime range sum: package
// Shared constants, controller state encoding and command/status bundles.
// ---------------------------------------------------------------------------
package pprs_pkg;

    localparam int DEF_VALUE_BITS = 20;
    localparam int SUM_W          = 40;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CONV   = 7'b0000010,
        ST_SCAN   = 7'b0000100,
        ST_TEST   = 7'b0001000,
        ST_DIV    = 7'b0010000,
        ST_REM    = 7'b0100000,
        ST_FINISH = 7'b1000000
    } t_state;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic div_init;
        logic div_start;
        logic div_step;
        logic d_next;
        logic accum;
        logic n_next;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic conv_done;
        logic empty;
        logic is_cand;
        logic sq_le_n;
        logic div_done;
        logic rem_zero;
        logic last_n;
        logic out_free;
    } t_sts;

endpackage

// ===== src/palindromic_prime_range_sum.sv =====
// ---------------------------------------------------------------------------
// Palindromic prime range sum: top level
// Sums every number of an inclusive range that is prime and a decimal
// palindrome.
// ---------------------------------------------------------------------------
// The input channel (i_valid, o_stall) takes one range per transfer; the
// output channel (o_valid, i_stall) returns one 40-bit sum per range.
// A range is taken only while the controller is idle; one range is worked
// on at a time, so the next range can be taken only once the controller
// is back in idle after the result is loaded. Work runs as binary to
// decimal conversion, then a scan over each number of the range, plus for
// each palindrome above one a trial division pass per divisor tried and a
// final test when no divisor is found, then the result is loaded. The
// bit-serial remainder unit sets the cost of each divisor.
// An empty range (end below start) returns 0 after the conversion.
// The result sits in an output register; a new range may be taken while
// it waits. If the receiver still stalls the previous result when a new
// sum is ready, the controller holds until that transfer completes.
// Reset returns the controller to idle and empties the output register.
// ---------------------------------------------------------------------------
module palindromic_prime_range_sum import pprs_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VALUE_BITS-1:0] i_range_start,
    input  logic [VALUE_BITS-1:0] i_range_end,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [SUM_W-1:0]      o_prime_palindrome_sum
);

    t_cmd   cmd;
    t_sts   sts;
    t_state state;

    pprs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_stall (o_stall),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_state    (state)
    );

    pprs_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_lo        (i_range_start),
        .i_hi        (i_range_end),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_sum       (o_prime_palindrome_sum)
    );

`include "palindromic_prime_range_sum_assert.svh"

`PPRS_ASSERT_SAME(a_emit_free, cmd.emit, sts.out_free, "Result overwrote a pending transfer.")
`PPRS_ASSERT_NEXT(a_load_conv, i_valid && !o_stall, state == ST_CONV, "Range did not convert.")
`PPRS_ASSERT_SAME(a_accum_cand, cmd.accum, sts.is_cand && !sts.sq_le_n, "Summed a bad number.")
`PPRS_ASSERT_NEXT(a_div_rem, (state == ST_DIV) && sts.div_done, state == ST_REM, "Late remainder.")

endmodule

// ===== src/pprs_dp.sv =====
// ---------------------------------------------------------------------------
// Palindromic prime range sum: datapath
// Candidate counter with a decimal shadow, binary to decimal converter,
// bit-serial remainder unit, divisor and square tracking, sum and output
// register.
// ---------------------------------------------------------------------------
module pprs_dp import pprs_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [VALUE_BITS-1:0] i_lo,
    input  logic [VALUE_BITS-1:0] i_hi,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [SUM_W-1:0]      o_sum
);

    localparam int DIGITS = (VALUE_BITS * 3) / 10 + 1;
    localparam int BW     = 4 * DIGITS;
    localparam int DW     = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQW    = VALUE_BITS + 2;
    localparam int CW     = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] r_n;
    logic [VALUE_BITS-1:0] r_hi;
    logic [VALUE_BITS-1:0] r_shift;
    logic [BW-1:0]         r_bcd;
    logic [CW-1:0]         r_cnt;
    logic [DW-1:0]         r_d;
    logic [SQW-1:0]        r_sq;
    logic [DW-1:0]         r_rem;
    logic [SUM_W-1:0]      r_acc;
    logic [SUM_W-1:0]      r_out;
    logic                  r_out_valid;

    logic [BW-1:0]         bcd_adj;
    logic [BW-1:0]         n_bcd_conv;
    logic [BW-1:0]         n_bcd_inc;
    logic                  inc_carry;
    logic [DW:0]           rem_sh;
    logic [DW:0]           rem_diff;
    logic [DW-1:0]         n_rem;
    logic                  mirror;
    logic                  pal;
    logic                  out_free;

    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
        n_bcd_conv = {bcd_adj[BW-2:0], r_shift[VALUE_BITS-1]};
    end

    always_comb begin
        inc_carry = 1'b1;
        n_bcd_inc = r_bcd;
        for (int i = 0; i < DIGITS; i++) begin
            if (inc_carry) begin
                if (r_bcd[4*i +: 4] == 4'd9) begin
                    n_bcd_inc[4*i +: 4] = 4'd0;
                end else begin
                    n_bcd_inc[4*i +: 4] = r_bcd[4*i +: 4] + 4'd1;
                    inc_carry = 1'b0;
                end
            end
        end
    end

    always_comb begin
        pal    = 1'b0;
        mirror = 1'b1;
        for (int l = 1; l <= DIGITS; l++) begin
            mirror = 1'b1;
            for (int k = 0; k < l; k++) begin
                if (r_bcd[4*k +: 4] != r_bcd[4*(l-1-k) +: 4]) begin
                    mirror = 1'b0;
                end
            end
            if (r_bcd[4*(l-1) +: 4] != 4'd0) begin
                pal = mirror;
            end
        end
    end

    always_comb begin
        rem_sh   = {r_rem, r_shift[VALUE_BITS-1]};
        rem_diff = rem_sh - {1'b0, r_d};
        if (rem_sh >= {1'b0, r_d}) begin
            n_rem = rem_diff[DW-1:0];
        end else begin
            n_rem = rem_sh[DW-1:0];
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_sts.conv_done = (r_cnt == CW'(VALUE_BITS - 1));
        o_sts.div_done  = (r_cnt == CW'(VALUE_BITS - 1));
        o_sts.empty     = (r_hi < r_n);
        o_sts.is_cand   = pal && (r_n > VALUE_BITS'(1));
        o_sts.sq_le_n   = (r_sq <= SQW'(r_n));
        o_sts.rem_zero  = (r_rem == '0);
        o_sts.last_n    = (r_n == r_hi);
        o_sts.out_free  = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n     <= i_lo;
            r_hi    <= i_hi;
            r_shift <= i_lo;
            r_bcd   <= '0;
            r_cnt   <= '0;
            r_acc   <= '0;
        end
        if (i_cmd.conv_step) begin
            r_bcd   <= n_bcd_conv;
            r_shift <= {r_shift[VALUE_BITS-2:0], 1'b0};
            r_cnt   <= r_cnt + CW'(1);
        end
        if (i_cmd.div_init) begin
            r_d  <= DW'(2);
            r_sq <= SQW'(4);
        end
        if (i_cmd.div_start) begin
            r_rem   <= '0;
            r_shift <= r_n;
            r_cnt   <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem   <= n_rem;
            r_shift <= {r_shift[VALUE_BITS-2:0], 1'b0};
            r_cnt   <= r_cnt + CW'(1);
        end
        if (i_cmd.d_next) begin
            r_d  <= r_d + DW'(1);
            r_sq <= r_sq + SQW'({r_d, 1'b1});
        end
        if (i_cmd.accum) begin
            r_acc <= r_acc + SUM_W'(r_n);
        end
        if (i_cmd.n_next) begin
            r_n   <= r_n + VALUE_BITS'(1);
            r_bcd <= n_bcd_inc;
        end
        if (i_cmd.emit) begin
            r_out <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sum       = r_out;

endmodule

// ===== src/pprs_ctrl.sv =====
// ---------------------------------------------------------------------------
// Palindromic prime range sum: controller
// Sequences conversion, the candidate scan and the trial division loop.
// ---------------------------------------------------------------------------
module pprs_ctrl import pprs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_stall,
    input  t_sts   i_sts,
    output t_cmd   o_cmd,
    output t_state o_state
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.conv_step = 1'b1;
                if (i_sts.conv_done) begin
                    n_state = i_sts.empty ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.is_cand) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = ST_TEST;
                end else if (i_sts.last_n) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.n_next = 1'b1;
                end
            end
            ST_TEST: begin
                if (i_sts.sq_le_n) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    o_cmd.accum = 1'b1;
                    if (i_sts.last_n) begin
                        n_state = ST_FINISH;
                    end else begin
                        o_cmd.n_next = 1'b1;
                        n_state      = ST_SCAN;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = ST_REM;
                end
            end
            ST_REM: begin
                if (!i_sts.rem_zero) begin
                    o_cmd.d_next = 1'b1;
                    n_state      = ST_TEST;
                end else if (i_sts.last_n) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.n_next = 1'b1;
                    n_state      = ST_SCAN;
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign o_state    = r_state;

endmodule
